>>> design/bsc_pkg.sv
package bsc_pkg;

    localparam int DATA_W     = 32;
    localparam int DUTY_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int FF_W       = PROD_W + 2;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 24;
    localparam int HI_W       = ACC_W - FRAC_SHIFT;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 56;

    // full-scale speed as a raw Q16.16 value; must be a power of two
    localparam int SPEED_FULL_SCALE      = 65536;
    localparam int SPEED_FULL_SCALE_LOG2 = 16;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_MODE   = 3'd1;
    localparam logic [2:0] REG_PWM_EN = 3'd2;
    localparam logic [2:0] REG_A1     = 3'd3;
    localparam logic [2:0] REG_A2     = 3'd4;
    localparam logic [2:0] REG_B0     = 3'd5;
    localparam logic [2:0] REG_B1     = 3'd6;
    localparam logic [2:0] REG_B2     = 3'd7;

    typedef enum logic [1:0] {
        MODE_OPEN   = 2'd0,
        MODE_CLOSED = 2'd1,
        MODE_OFF    = 2'd2,
        MODE_HOLD   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [DATA_W-1:0] target_speed;
        mode_t             loop_mode;
        logic              pwm_enable;
        logic [DATA_W-1:0] coef_a1;
        logic [DATA_W-1:0] coef_a2;
        logic [DATA_W-1:0] coef_b0;
        logic [DATA_W-1:0] coef_b1;
        logic [DATA_W-1:0] coef_b2;
    } cfg_t;

endpackage

>>> design/bsc_feedforward.sv
module bsc_feedforward
    import bsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [DATA_W-1:0]       meas,
    input  cfg_t                    cfg,
    output logic signed [FF_W-1:0]  ff_sum
);

    logic signed [DATA_W-1:0] err_prev_reg, err_prev_next;
    logic signed [DATA_W-1:0] err_prev2_reg, err_prev2_next;
    logic signed [FF_W-1:0]   ff_sum_reg, ff_sum_next;

    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W-1:0] err;
    logic signed [PROD_W-1:0] p0, p1, p2;

    // error = target - measured, clamped to 32 bits
    assign diff = $signed({cfg.target_speed[DATA_W-1], cfg.target_speed})
                - $signed({meas[DATA_W-1], meas});

    always_comb
    begin
        if (diff[DATA_W] != diff[DATA_W-1])
        begin
            err = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            err = diff[DATA_W-1:0];
        end
    end

    assign p0 = $signed(cfg.coef_b0) * err;
    assign p1 = $signed(cfg.coef_b1) * err_prev_reg;
    assign p2 = $signed(cfg.coef_b2) * err_prev2_reg;

    always_comb
    begin
        ff_sum_next    = ff_sum_reg;
        err_prev_next  = err_prev_reg;
        err_prev2_next = err_prev2_reg;
        if (load)
        begin
            ff_sum_next    = FF_W'(p0) + FF_W'(p1) + FF_W'(p2);
            err_prev_next  = err;
            err_prev2_next = err_prev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
        end
        else
        begin
            err_prev_reg  <= err_prev_next;
            err_prev2_reg <= err_prev2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ff_sum_reg <= ff_sum_next;
    end

    assign ff_sum = ff_sum_reg;

endmodule

>>> design/bsc_feedback.sv
module bsc_feedback
    import bsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic signed [FF_W-1:0]  ff_sum,
    input  cfg_t                    cfg,
    output logic [DATA_W-1:0]       drive
);

    logic signed [DATA_W-1:0] drive_prev_reg, drive_prev_next;
    logic signed [DATA_W-1:0] drive_prev2_reg, drive_prev2_next;

    logic signed [PROD_W-1:0] q1, q2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [HI_W-1:0]   hi;
    logic signed [DATA_W-1:0] law;
    logic signed [DATA_W-1:0] u;

    assign q1 = $signed(cfg.coef_a1) * drive_prev_reg;
    assign q2 = $signed(cfg.coef_a2) * drive_prev2_reg;

    // exact sum plus half an LSB, then floor to Q16.16
    assign acc = ACC_W'(ff_sum) - ACC_W'(q1) - ACC_W'(q2)
               + ACC_W'(2 ** (FRAC_SHIFT - 1));
    assign hi  = acc[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        if ((&hi[HI_W-1:DATA_W-1]) || !(|hi[HI_W-1:DATA_W-1]))
        begin
            law = hi[DATA_W-1:0];
        end
        else
        begin
            law = hi[HI_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        unique case (cfg.loop_mode)
            MODE_OPEN:   u = cfg.target_speed;
            MODE_CLOSED: u = law;
            MODE_OFF:    u = '0;
            MODE_HOLD:   u = drive_prev_reg;
        endcase
    end

    always_comb
    begin
        drive_prev_next  = drive_prev_reg;
        drive_prev2_next = drive_prev2_reg;
        if (load)
        begin
            drive_prev_next  = u;
            drive_prev2_next = drive_prev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_prev_reg  <= '0;
            drive_prev2_reg <= '0;
        end
        else
        begin
            drive_prev_reg  <= drive_prev_next;
            drive_prev2_reg <= drive_prev2_next;
        end
    end

    assign drive = drive_prev_reg;

endmodule

>>> design/bsc_output.sv
module bsc_output
    import bsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   load,
    input  logic [DATA_W-1:0]      drive,
    input  cfg_t                   cfg,
    output logic [TDATA_OUT_W-1:0] tdata
);

    localparam int SCALED_W = DATA_W + 2 + DUTY_W;
    localparam int QUOT_W   = SCALED_W - SPEED_FULL_SCALE_LOG2 - 1;

    logic [DATA_W-1:0]   drive_reg, drive_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                stop_reg, stop_next;

    logic signed [DATA_W+1:0] spd_sum;
    logic [SCALED_W-1:0]      scaled;
    logic [QUOT_W-1:0]        quot;
    logic [DUTY_W-1:0]        duty;
    logic                     stop;

    // duty = (SPEED_FULL_SCALE + u) * 2^16 / (2 * SPEED_FULL_SCALE), rounded half up
    assign spd_sum = (DATA_W+2)'(SPEED_FULL_SCALE) + {{2{drive[DATA_W-1]}}, drive};
    assign scaled  = SCALED_W'({spd_sum[DATA_W:0], {DUTY_W{1'b0}}})
                   + SCALED_W'(SPEED_FULL_SCALE);
    assign quot    = scaled[SCALED_W-1:SPEED_FULL_SCALE_LOG2+1];
    assign stop    = !cfg.pwm_enable || (cfg.loop_mode == MODE_OFF);

    always_comb
    begin
        priority if (stop || spd_sum[DATA_W+1] || (spd_sum == '0))
        begin
            duty = '0;
        end
        else if (|quot[QUOT_W-1:DUTY_W])
        begin
            duty = {DUTY_W{1'b1}};
        end
        else
        begin
            duty = quot[DUTY_W-1:0];
        end
    end

    always_comb
    begin
        drive_next = drive_reg;
        duty_next  = duty_reg;
        stop_next  = stop_reg;
        if (load)
        begin
            drive_next = drive;
            duty_next  = duty;
            stop_next  = stop;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
        duty_reg  <= duty_next;
        stop_reg  <= stop_next;
    end

    assign tdata = TDATA_OUT_W'({stop_reg, duty_reg, drive_reg});

endmodule

>>> design/biquad_speed_controller.sv
// Biquad speed controller: one control tick per input beat.
//
// Slave stream carries the measured speed (signed Q16.16). Master stream
// returns one beat per tick: drive value, PWM duty (unsigned Q0.16) and the
// motor stop flag. Write target, loop mode, PWM enable and the five
// coefficients through the cfg port while no tick is in flight.
//
// A beat accepted on the slave side passes through the input register,
// the feedforward products, the feedback sum and the duty register.
// Throughput: one beat per cycle while the receiver does not stall.
// The drive history register feeds the a1/a2 products of the next tick,
// and the feedback multiply-add returns into it combinationally.
//
// Reset clears all configuration registers, the error and drive histories
// and every valid flag; no beat is presented until a new one is accepted.
// When the receiver stalls, the result beat holds on the master side; the
// inner stages keep filling until full, then s_tready drops.
module biquad_speed_controller
    import bsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [31:0] measured_speed
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [31:0] drive_value, [47:32] duty_cycle,
                                              // [48] motor_stop, [55:49] zero
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic              in_vld_reg, in_vld_next;
    logic              ff_vld_reg, ff_vld_next;
    logic              fb_vld_reg, fb_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic [DATA_W-1:0] meas_reg, meas_next;

    logic rdy_out, rdy_fb, rdy_ff;
    logic adv_in, adv_ff, adv_fb;
    logic in_take;

    logic signed [FF_W-1:0] ff_sum;
    logic [DATA_W-1:0]      drive;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TARGET: cfg_next.target_speed = cfg_data;
                REG_MODE:   cfg_next.loop_mode    = mode_t'(cfg_data[1:0]);
                REG_PWM_EN: cfg_next.pwm_enable   = cfg_data[0];
                REG_A1:     cfg_next.coef_a1      = cfg_data;
                REG_A2:     cfg_next.coef_a2      = cfg_data;
                REG_B0:     cfg_next.coef_b0      = cfg_data;
                REG_B1:     cfg_next.coef_b1      = cfg_data;
                REG_B2:     cfg_next.coef_b2      = cfg_data;
            endcase
        end
    end

    // a stage can take a new beat when it is empty or its successor can take one
    assign rdy_out  = !out_vld_reg || m_tready;
    assign rdy_fb   = !fb_vld_reg || rdy_out;
    assign rdy_ff   = !ff_vld_reg || rdy_fb;
    assign s_tready = !in_vld_reg || rdy_ff;

    assign in_take = s_tvalid && s_tready;
    assign adv_in  = in_vld_reg && rdy_ff;
    assign adv_ff  = ff_vld_reg && rdy_fb;
    assign adv_fb  = fb_vld_reg && rdy_out;

    always_comb
    begin
        in_vld_next  = in_take || (in_vld_reg && !adv_in);
        ff_vld_next  = adv_in || (ff_vld_reg && !adv_ff);
        fb_vld_next  = adv_ff || (fb_vld_reg && !adv_fb);
        out_vld_next = adv_fb || (out_vld_reg && !m_tready);
        meas_next    = in_take ? s_tdata : meas_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            in_vld_reg  <= 1'b0;
            ff_vld_reg  <= 1'b0;
            fb_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            ff_vld_reg  <= ff_vld_next;
            fb_vld_reg  <= fb_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg <= meas_next;
    end

    bsc_feedforward u_ff (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv_in),
        .meas   (meas_reg),
        .cfg    (cfg_reg),
        .ff_sum (ff_sum)
    );

    bsc_feedback u_fb (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv_ff),
        .ff_sum (ff_sum),
        .cfg    (cfg_reg),
        .drive  (drive)
    );

    bsc_output u_out (
        .clk   (clk),
        .load  (adv_fb),
        .drive (drive),
        .cfg   (cfg_reg),
        .tdata (m_tdata)
    );

    assign m_tvalid = out_vld_reg;

endmodule

>>> design/bsc_checker.sv
module bsc_checker
    import bsc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // with the master side free, the pipeline never pushes back
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with output free");

    // stopped motor drives no duty
    a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[48] |-> m_tdata[47:32] == 16'h0000)
        else $error("duty nonzero with motor stopped");

    // drive at or above full scale saturates the duty high
    a_duty_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[48] && !m_tdata[31] && (m_tdata[30:16] != 15'h0000)
        |-> m_tdata[47:32] == 16'hFFFF)
        else $error("duty not saturated high");

    // drive below minus full scale saturates the duty low
    a_duty_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[31] && (m_tdata[30:16] != 15'h7FFF)
        |-> m_tdata[47:32] == 16'h0000)
        else $error("duty not saturated low");

endmodule

bind biquad_speed_controller bsc_checker u_bsc_checker (.*);

>>> bench/speed_loop_checker.sv
module speed_loop_checker
    import bsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [31:0] measured_speed
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,   // [31:0] drive_value, [47:32] duty_cycle,
                                              // [48] motor_stop, [55:49] zero
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    output int                     outstanding,
    output int                     mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDE_W = 70;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic [DUTY_W-1:0] duty;
        logic              stop;
    } tick_out_t;

    localparam wide_t HALF_LSB = 70'sd8388608;

    // register copies
    logic signed [DATA_W-1:0] target;
    mode_t                    loop_mode;
    logic                     pwm_enable;
    logic signed [DATA_W-1:0] coef_a1;
    logic signed [DATA_W-1:0] coef_a2;
    logic signed [DATA_W-1:0] coef_b0;
    logic signed [DATA_W-1:0] coef_b1;
    logic signed [DATA_W-1:0] coef_b2;

    // error and drive histories
    logic signed [DATA_W-1:0] err_z1;
    logic signed [DATA_W-1:0] err_z2;
    logic signed [DATA_W-1:0] drive_z1;
    logic signed [DATA_W-1:0] drive_z2;

    tick_out_t pending_ticks[$];

    function automatic wide_t widen(logic signed [DATA_W-1:0] x);
        return x;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_word(wide_t v);
        if (v > widen(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < widen(32'sh8000_0000))
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    // exact Q24.40 sum, round half up to Q16.16
    function automatic logic signed [DATA_W-1:0] biquad_sum(logic signed [DATA_W-1:0] err);
        wide_t acc;
        acc = widen(coef_b0) * widen(err) + widen(coef_b1) * widen(err_z1)
            + widen(coef_b2) * widen(err_z2) - widen(coef_a1) * widen(drive_z1)
            - widen(coef_a2) * widen(drive_z2) + HALF_LSB;
        return clamp_word(acc >>> FRAC_SHIFT);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for(logic signed [DATA_W-1:0] drive);
        longint num;
        longint q;
        num = (longint'(SPEED_FULL_SCALE) + longint'(drive)) * (longint'(1) << DUTY_W);
        if (num <= 0)
            return '0;
        q = (num + SPEED_FULL_SCALE) / (2 * SPEED_FULL_SCALE);
        if (q >= (longint'(1) << DUTY_W))
            return '1;
        return q[DUTY_W-1:0];
    endfunction

    function automatic tick_out_t next_tick(logic signed [DATA_W-1:0] speed);
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] drive;
        tick_out_t                r;
        err = clamp_word(widen(target) - widen(speed));
        case (loop_mode)
            MODE_CLOSED: drive = biquad_sum(err);
            MODE_OPEN:   drive = target;
            MODE_OFF:    drive = '0;
            default:     drive = drive_z1;
        endcase
        // histories shift whatever the mode
        err_z2   = err_z1;
        err_z1   = err;
        drive_z2 = drive_z1;
        drive_z1 = drive;
        r.drive = drive;
        r.stop  = !pwm_enable || loop_mode == MODE_OFF;
        r.duty  = r.stop ? '0 : duty_for(drive);
        return r;
    endfunction

    task automatic compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_out_t seen;
        tick_out_t want;
        if (!rst_n)
        begin
            target     = '0;
            loop_mode  = MODE_OPEN;
            pwm_enable = 1'b0;
            coef_a1    = '0;
            coef_a2    = '0;
            coef_b0    = '0;
            coef_b1    = '0;
            coef_b2    = '0;
            err_z1     = '0;
            err_z2     = '0;
            drive_z1   = '0;
            drive_z2   = '0;
            mismatches = 0;
            pending_ticks.delete();
            outstanding <= 0;
        end
        else
        begin
            // check the outgoing beat before queuing this edge's tick
            if (m_tvalid && m_tready)
            begin
                seen.drive = m_tdata[31:0];
                seen.duty  = m_tdata[47:32];
                seen.stop  = m_tdata[48];
                if (pending_ticks.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_ticks.pop_front();
                    compare_field("drive_value", want.drive, seen.drive);
                    compare_field("duty_cycle", DATA_W'(want.duty), DATA_W'(seen.duty));
                    compare_field("motor_stop", DATA_W'(want.stop), DATA_W'(seen.stop));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TARGET: target     = cfg_data;
                    REG_MODE:   loop_mode  = mode_t'(cfg_data[1:0]);
                    REG_PWM_EN: pwm_enable = cfg_data[0];
                    REG_A1:     coef_a1    = cfg_data;
                    REG_A2:     coef_a2    = cfg_data;
                    REG_B0:     coef_b0    = cfg_data;
                    REG_B1:     coef_b1    = cfg_data;
                    REG_B2:     coef_b2    = cfg_data;
                    default:    ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_ticks.push_back(next_tick(s_tdata));
            outstanding <= pending_ticks.size();
        end
    end

endmodule

>>> bench/biquad_speed_controller_tb.sv
module biquad_speed_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 23;
    localparam int CALM_PHASES   = 3;
    localparam int PHASE_ITEMS   = 50;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;    // [31:0] measured_speed
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;    // [31:0] drive_value, [47:32] duty_cycle,
                                        // [48] motor_stop, [55:49] zero
    logic                   cfg_wr_en;
    logic [2:0]             cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    int          outstanding;
    int          mismatches;
    int          quiet_cycles = 0;
    bit          src_gaps;
    bit          sink_stalls;
    logic [31:0] target_now;

    biquad_speed_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    speed_loop_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // target within +-2.0 mostly
    function automatic logic [31:0] target_word();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return corner_word();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Q8.24 coefficient within +-1.0 mostly
    function automatic logic [31:0] coef_word();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return corner_word();
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    // measured speed mostly close to the target
    function automatic logic [31:0] speed_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return corner_word();
            default: return target_now + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    task automatic cfg_write(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == REG_TARGET)
            target_now = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_speed(logic [31:0] speed);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= speed;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait until every queued tick has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic randomize_setup();
        mode_t mode;
        int    pick;
        pick = $urandom_range(0, 19);
        mode = pick < 10 ? MODE_CLOSED : pick < 14 ? MODE_OPEN : pick < 17 ? MODE_OFF : MODE_HOLD;
        // junk in the upper bits must be ignored
        cfg_write(REG_MODE, ($urandom() & ~32'h3) | {30'd0, mode});
        cfg_write(REG_PWM_EN, ($urandom() & ~32'h1) | {31'd0, $urandom_range(0, 4) != 0});
        cfg_write(REG_TARGET, target_word());
        cfg_write(REG_A1, coef_word());
        cfg_write(REG_A2, coef_word());
        cfg_write(REG_B0, coef_word());
        cfg_write(REG_B1, coef_word());
        cfg_write(REG_B2, coef_word());
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        target_now  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: open loop, PWM disabled
        send_speed(32'h0000_0000);
        send_speed(32'h7FFF_FFFF);
        send_speed(32'h8000_0000);
        drain();

        // open loop at full target, error saturating high
        cfg_write(REG_TARGET, 32'h7FFF_FFFF);
        cfg_write(REG_PWM_EN, 32'h1);
        send_speed(32'h8000_0000);
        send_speed(32'h7FFF_FFFF);
        drain();

        // closed loop with extreme coefficients, error saturating low
        cfg_write(REG_TARGET, 32'h8000_0000);
        cfg_write(REG_MODE, {30'd0, MODE_CLOSED});
        cfg_write(REG_A1, 32'h7FFF_FFFF);
        cfg_write(REG_A2, 32'h8000_0000);
        cfg_write(REG_B0, 32'h8000_0000);
        cfg_write(REG_B1, 32'h7FFF_FFFF);
        cfg_write(REG_B2, 32'h8000_0000);
        repeat (4) send_speed(32'h7FFF_FFFF);
        send_speed(32'h8000_0000);
        drain();

        // gain 0.5: half LSB rounds up, minus half rounds to zero
        cfg_write(REG_TARGET, 32'h0);
        cfg_write(REG_A1, 32'h0);
        cfg_write(REG_A2, 32'h0);
        cfg_write(REG_B0, 32'h0080_0000);
        cfg_write(REG_B1, 32'h0);
        cfg_write(REG_B2, 32'h0);
        send_speed(32'hFFFF_FFFF);
        send_speed(32'h0000_0001);
        send_speed(32'hFFFF_0000);
        send_speed(32'h0001_0000);
        drain();

        // unity gain: duty saturates at both ends
        cfg_write(REG_B0, 32'h0100_0000);
        send_speed(32'hFFFF_0000);
        send_speed(32'h0001_0000);
        drain();

        // hold mode keeps the previous drive
        cfg_write(REG_MODE, {30'd0, MODE_HOLD});
        send_speed(32'h1234_5678);
        send_speed(32'h8765_4321);
        drain();

        cfg_write(REG_MODE, {30'd0, MODE_OFF});
        send_speed(32'h0000_0100);
        send_speed(32'hFFFF_FF00);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p >= RANDOM_PHASES - CALM_PHASES)
            begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            else
            begin
                src_gaps    = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
            end
            randomize_setup();
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_speed(speed_sample());
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> biquad_speed_controller.f
design/bsc_pkg.sv
design/bsc_feedforward.sv
design/bsc_feedback.sv
design/bsc_output.sv
design/biquad_speed_controller.sv
design/bsc_checker.sv
bench/speed_loop_checker.sv
bench/biquad_speed_controller_tb.sv
